/* rtl/core/earpm_pkg.sv */
// Shared types, widths and constants for the encoder angle rpm estimator.
package earpm_pkg;

  localparam int ANGLE_W = 14;
  localparam int TS_W    = 64;
  localparam int RPM_W   = 32;

  // Dividend is |delta| * RPM_NUM, at most 8192 * 937500, which needs 33 bits.
  localparam int NUM_W   = 33;
  // Divisor is dt * pole_pairs with dt below 2^33 and pole_pairs below 2^7.
  localparam int DEN_W   = 40;
  localparam int DT_W    = 33;

  localparam int POLL_W  = 20;
  localparam int PP_W    = 7;
  localparam int ALPHA_W = 17;
  localparam int ZTO_W   = 27;
  localparam int CFG_W   = 27;
  localparam int CFG_IDX_W = 2;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [19:0] RPM_NUM = 20'd937500;
  localparam logic signed [14:0] HALF_STEPS = 15'sd8192;
  localparam logic signed [14:0] ANGLE_STEPS = 15'sd16384 - 15'sd1 + 15'sd1;
  localparam logic signed [RPM_W-1:0] MOTION_Q8 = 32'sd128;
  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [POLL_W-1:0]  POLL_RESET  = 20'd10000;
  localparam logic [PP_W-1:0]    PP_RESET    = 7'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
  localparam logic [ZTO_W-1:0]   ZTO_RESET   = 27'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_POLL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZTO   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MULD,
    ST_DIVGO,
    ST_DIV,
    ST_SAT,
    ST_PREP,
    ST_EMA,
    ST_FIN
  } st_t;

endpackage

/* rtl/core/earpm_div.sv */
// Restoring divider that retires one quotient bit per cycle.
module earpm_div #(
  parameter int NUM_W = earpm_pkg::NUM_W,
  parameter int DEN_W = earpm_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] qr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W+1:0] trial;
  logic             ge;

  // The partial remainder stays below the divisor, so the shifted value
  // fits one more bit and one extra bit catches the borrow.
  assign trial = {1'b0, rem, qr[NUM_W-1]} - {2'b00, den};
  assign ge    = ~trial[DEN_W+1];
  assign quot  = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qr  <= num;
    end else if (busy) begin
      rem <= ge ? trial[DEN_W-1:0] : {rem[DEN_W-2:0], qr[NUM_W-1]};
      qr  <= {qr[NUM_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/encoder_angle_rpm_estimator.sv */
// Top level of the encoder angle rpm estimator: sequencer, state and datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    timestamp_us, angle_high, angle_low,
//                                              transfer_failed
//   out      output     out_valid / out_ready  rpm_filtered, rpm_raw
//   cfg      input      cfg_write_en           cfg_index, cfg_data
//
// A word that is early, failed or only primes the angle goes from the check
// step back to idle and returns nothing. A word that yields a result passes
// through the multiply, divide, saturate, prepare, filter and final steps
// before out_valid rises. In the divide step the bit-serial divider takes the
// scaled angle delta over dt * pole_pairs one quotient bit per cycle, and
// then hands the quotient over.
// Synchronous reset clears the sequencer, the stored angle and times, the
// filter state and the registers to their default values.
// The input is taken only while the sequencer is idle; a result waiting on
// out_ready does not block the next input, but holds the sequencer in its
// final step until the output register frees up.
module encoder_angle_rpm_estimator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [earpm_pkg::TS_W-1:0]            timestamp_us,
  input  logic [7:0]                            angle_high,
  input  logic [7:0]                            angle_low,
  input  logic                                  transfer_failed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [earpm_pkg::RPM_W-1:0]    rpm_filtered,
  output logic signed [earpm_pkg::RPM_W-1:0]    rpm_raw,
  input  logic                                  cfg_write_en,
  input  logic [earpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [earpm_pkg::CFG_W-1:0]           cfg_data
);

  localparam int TS_W  = earpm_pkg::TS_W;
  localparam int RPM_W = earpm_pkg::RPM_W;
  localparam int DT_W  = earpm_pkg::DT_W;
  localparam int NUM_W = earpm_pkg::NUM_W;
  localparam int DEN_W = earpm_pkg::DEN_W;

  // Configuration registers.
  logic [earpm_pkg::POLL_W-1:0]  poll_interval_us;
  logic [earpm_pkg::PP_W-1:0]    pole_pairs;
  logic [earpm_pkg::ALPHA_W-1:0] ema_alpha;
  logic [earpm_pkg::ZTO_W-1:0]   zero_timeout_us;

  // Estimator state.
  logic [earpm_pkg::ANGLE_W-1:0] prev_angle;
  logic                          prev_valid;
  logic [TS_W-1:0]               prev_time;
  logic [TS_W-1:0]               motion_time;
  logic signed [RPM_W-1:0]       smoothed;

  // Sequencer.
  earpm_pkg::st_t state, state_next;

  // Latched input word and per-word working registers.
  logic [TS_W-1:0]               ts_r;
  logic [earpm_pkg::ANGLE_W-1:0] angle_r;
  logic                          fail_r;
  logic signed [14:0]            delta_r;
  logic [DT_W-1:0]               dt_r;
  logic                          zero_q_r;
  logic [NUM_W-1:0]              num_r;
  logic signed [RPM_W-1:0]       raw_r;
  logic signed [RPM_W:0]         diff_r;
  logic                          tmo_r;
  logic signed [earpm_pkg::MUL_P_W-1:0] mul_p;

  // Combinational terms.
  logic [TS_W-1:0]               dt;
  logic                          early;
  logic [earpm_pkg::ANGLE_W-1:0] angle_in;
  logic signed [14:0]            delta_raw;
  logic signed [14:0]            delta_wrap;
  logic [13:0]                   mag;
  logic [33:0]                   num_full;
  logic [earpm_pkg::PP_W-1:0]    pp_eff;
  logic [earpm_pkg::ALPHA_W-1:0] a_eff;
  logic signed [earpm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [earpm_pkg::MUL_B_W-1:0] mul_b;
  logic [NUM_W-1:0]              quot;
  logic                          div_done;
  logic                          div_start;
  logic signed [RPM_W-1:0]       raw_sat;
  logic                          motion;
  logic [TS_W-1:0]               since_motion;
  logic signed [earpm_pkg::MUL_P_W-1:0] ema_sum;
  logic signed [RPM_W-1:0]       smoothed_next;
  logic                          fin_go;

  // ---------------------------------------------------------------------
  // Configuration writes. All four indexes are defined, so every write lands.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_interval_us <= earpm_pkg::POLL_RESET;
      pole_pairs       <= earpm_pkg::PP_RESET;
      ema_alpha        <= earpm_pkg::ALPHA_RESET;
      zero_timeout_us  <= earpm_pkg::ZTO_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        earpm_pkg::CFG_POLL:  poll_interval_us <= cfg_data[earpm_pkg::POLL_W-1:0];
        earpm_pkg::CFG_PP:    pole_pairs       <= cfg_data[earpm_pkg::PP_W-1:0];
        earpm_pkg::CFG_ALPHA: ema_alpha        <= cfg_data[earpm_pkg::ALPHA_W-1:0];
        earpm_pkg::CFG_ZTO:   zero_timeout_us  <= cfg_data[earpm_pkg::ZTO_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero pole pairs behaves as one, and alpha saturates at unity.
  assign pp_eff = (pole_pairs == '0) ? earpm_pkg::PP_W'(1) : pole_pairs;
  assign a_eff  = ema_alpha[earpm_pkg::ALPHA_W-1] ? earpm_pkg::ONE_Q16 : ema_alpha;

  // ---------------------------------------------------------------------
  // Classification of the latched word. A negative interval (time running
  // backwards) counts as early, just like one shorter than half the poll.
  // ---------------------------------------------------------------------
  assign dt       = ts_r - prev_time;
  assign early    = dt[TS_W-1] ||
                    (dt < {{(TS_W-earpm_pkg::POLL_W+1){1'b0}},
                           poll_interval_us[earpm_pkg::POLL_W-1:1]});
  assign angle_in = angle_r;

  // Shortest way around the circle, kept within half a turn.
  assign delta_raw = $signed({1'b0, angle_in}) - $signed({1'b0, prev_angle});
  always_comb begin
    if (delta_raw > earpm_pkg::HALF_STEPS) begin
      delta_wrap = delta_raw - earpm_pkg::ANGLE_STEPS;
    end else if (delta_raw < -earpm_pkg::HALF_STEPS) begin
      delta_wrap = delta_raw + earpm_pkg::ANGLE_STEPS;
    end else begin
      delta_wrap = delta_raw;
    end
  end

  assign mag      = delta_r[14] ? 14'(-delta_r) : delta_r[13:0];
  assign num_full = 34'(mag) * 34'(earpm_pkg::RPM_NUM);

  // ---------------------------------------------------------------------
  // Next-state logic.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      earpm_pkg::ST_IDLE: begin
        if (in_valid) state_next = earpm_pkg::ST_CHECK;
      end
      earpm_pkg::ST_CHECK: begin
        if (early || fail_r || !prev_valid) begin
          state_next = earpm_pkg::ST_IDLE;
        end else begin
          state_next = earpm_pkg::ST_MULD;
        end
      end
      earpm_pkg::ST_MULD:  state_next = earpm_pkg::ST_DIVGO;
      earpm_pkg::ST_DIVGO: state_next = earpm_pkg::ST_DIV;
      earpm_pkg::ST_DIV: begin
        if (div_done) state_next = earpm_pkg::ST_SAT;
      end
      earpm_pkg::ST_SAT:   state_next = earpm_pkg::ST_PREP;
      earpm_pkg::ST_PREP:  state_next = earpm_pkg::ST_EMA;
      earpm_pkg::ST_EMA:   state_next = earpm_pkg::ST_FIN;
      earpm_pkg::ST_FIN: begin
        if (!out_valid || out_ready) state_next = earpm_pkg::ST_IDLE;
      end
      default: state_next = earpm_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer outputs: handshake, divider start and multiplier operands.
  // The one multiplier forms dt * pole_pairs first and the filter product
  // alpha * (raw - smoothed) later.
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    fin_go    = 1'b0;
    mul_a     = $signed({1'b0, dt_r});
    mul_b     = $signed({{(earpm_pkg::MUL_B_W-earpm_pkg::PP_W){1'b0}}, pp_eff});
    unique case (state)
      earpm_pkg::ST_IDLE:  in_ready  = 1'b1;
      earpm_pkg::ST_DIVGO: div_start = 1'b1;
      earpm_pkg::ST_EMA: begin
        mul_a = $signed({diff_r[RPM_W], diff_r});
        mul_b = $signed({1'b0, a_eff});
      end
      earpm_pkg::ST_FIN:   fin_go    = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= earpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: quotient of |delta| * 937500 over dt * pole_pairs.
  // ---------------------------------------------------------------------
  earpm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_r),
    .den   (mul_p[DEN_W-1:0]),
    .done  (div_done),
    .quot  (quot)
  );

  // Round toward zero already holds for the magnitude; apply the sign and
  // clamp to the signed 32-bit range; a zero or too long interval gives zero.
  always_comb begin
    if (zero_q_r) begin
      raw_sat = '0;
    end else if (delta_r[14]) begin
      raw_sat = (quot[NUM_W-1:RPM_W-1] != '0) ? {1'b1, {(RPM_W-1){1'b0}}}
                                              : -$signed(quot[RPM_W-1:0]);
    end else begin
      raw_sat = (quot[NUM_W-1:RPM_W-1] != '0) ? {1'b0, {(RPM_W-1){1'b1}}}
                                              : $signed(quot[RPM_W-1:0]);
    end
  end

  assign motion       = (raw_r > earpm_pkg::MOTION_Q8) || (raw_r < -earpm_pkg::MOTION_Q8);
  assign since_motion = ts_r - motion_time;

  // The filter is rewritten as old + alpha * (raw - old), scaled by 2^16,
  // plus one half before the floor shift.
  assign ema_sum = $signed({{(earpm_pkg::MUL_P_W-RPM_W-16){smoothed[RPM_W-1]}},
                            smoothed, 16'h0000})
                   + mul_p + earpm_pkg::MUL_P_W'(32768);
  assign smoothed_next = tmo_r ? '0 : ema_sum[RPM_W+15:16];

  // ---------------------------------------------------------------------
  // Working registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ts_r    <= timestamp_us;
      angle_r <= {angle_high, angle_low[5:0]};
      fail_r  <= transfer_failed;
    end
    if (state == earpm_pkg::ST_CHECK) begin
      delta_r  <= delta_wrap;
      dt_r     <= dt[DT_W-1:0];
      zero_q_r <= (dt == '0) || (dt[TS_W-1:DT_W] != '0);
    end
    if (state == earpm_pkg::ST_MULD) begin
      num_r <= num_full[NUM_W-1:0];
    end
    if (state == earpm_pkg::ST_MULD || state == earpm_pkg::ST_EMA) begin
      mul_p <= mul_a * mul_b;
    end
    if (state == earpm_pkg::ST_SAT) begin
      raw_r <= raw_sat;
    end
    if (state == earpm_pkg::ST_PREP) begin
      diff_r <= $signed({raw_r[RPM_W-1], raw_r}) - $signed({smoothed[RPM_W-1], smoothed});
      tmo_r  <= !motion && (since_motion > {{(TS_W-earpm_pkg::ZTO_W){1'b0}}, zero_timeout_us});
    end
  end

  // ---------------------------------------------------------------------
  // Estimator state. Any word that is not early moves the sample time and
  // the stored angle; a failed read clears the angle.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_angle  <= '0;
      prev_valid  <= 1'b0;
      prev_time   <= '0;
      motion_time <= '0;
      smoothed    <= '0;
    end else begin
      if (state == earpm_pkg::ST_CHECK && !early) begin
        prev_time  <= ts_r;
        prev_angle <= fail_r ? '0 : angle_in;
        prev_valid <= !fail_r;
      end
      if (state == earpm_pkg::ST_PREP && motion) begin
        motion_time <= ts_r;
      end
      if (fin_go) begin
        smoothed <= smoothed_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      rpm_filtered <= smoothed_next;
      rpm_raw      <= raw_r;
    end
  end

`ifndef SYNTH
  // The divider finishes only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == earpm_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  // A good word with no stored angle primes the angle and marks it valid.
  a_prime_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == earpm_pkg::ST_CHECK && !early && !fail_r && !prev_valid) |=> prev_valid)
    else $error("priming word did not mark the angle valid");

  // A new result appears only out of the final step.
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == earpm_pkg::ST_FIN)
    else $error("result raised outside the final step");

  // A failed read that is not early leaves no valid angle behind.
  a_fail_clears: assert property (@(posedge clk) disable iff (rst)
    (state == earpm_pkg::ST_CHECK && !early && fail_r) |=> !prev_valid && prev_angle == '0)
    else $error("failed read left an angle stored");
`endif

endmodule
